### src/bqlp_pkg.sv
// Package for the biquad low-pass filter unit.
// Holds default sizes, register indexes and the shared multiply-accumulate control types.
// No dependencies; imported by bqlp_mac and biquad_lowpass_filter_unit.
package bqlp_pkg;

    // Default sizes of the datapath.
    localparam int SAMPLE_WIDTH_DEF   = 16;
    localparam int COEF_FRAC_BITS_DEF = 16;
    localparam int DELAY_WIDTH_DEF    = 24;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FILTER_ENABLE = 2'd0,
        REG_COEF_B0       = 2'd1,
        REG_COEF_A1       = 2'd2,
        REG_COEF_A2       = 2'd3
    } cfg_reg_t;

    // Accumulator operations of the shared unit.
    typedef enum logic [1:0] {
        ACC_HOLD = 2'd0,
        ACC_LOAD = 2'd1,
        ACC_SUB  = 2'd2
    } acc_op_t;

    // Control bundle from the sequencer to the shared unit.
    typedef struct packed {
        logic    mul_en;
        acc_op_t acc_op;
    } mac_ctl_t;

endpackage

### src/bqlp_mac.sv
// Shared signed multiplier with a registered product and an accumulator.
// Depends on bqlp_pkg for the control bundle type.
// The product is registered before it reaches the accumulator.
module bqlp_mac #(
    parameter int A_W   = 26,
    parameter int B_W   = 18,
    parameter int ACC_W = 50
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bqlp_pkg::mac_ctl_t            ctl,
    input  logic signed [A_W-1:0]         mul_a,
    input  logic signed [B_W-1:0]         mul_b,
    input  logic signed [ACC_W-1:0]       load_val,
    output logic signed [A_W+B_W-1:0]     prod,
    output logic signed [ACC_W-1:0]       acc
);
    import bqlp_pkg::*;

    localparam int P_W = A_W + B_W;

    logic signed [P_W-1:0]   prod_reg;
    logic signed [P_W-1:0]   prod_next;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [ACC_W-1:0] prod_ext;

    // One multiplication per cycle while mul_en is set, full product width.
    assign prod_next = mul_a * mul_b;
    assign prod_ext  = {{(ACC_W-P_W){prod_reg[P_W-1]}}, prod_reg};

    // Accumulator update selected by the sequencer.
    always_comb
    begin
        case (ctl.acc_op)
            ACC_LOAD: acc_next = load_val;
            ACC_SUB:  acc_next = acc_reg - prod_ext;
            ACC_HOLD: acc_next = acc_reg;
            default:  acc_next = acc_reg;
        endcase
    end

    // Product register carries payload only.
    always_ff @(posedge clk)
    begin
        if (ctl.mul_en)
        begin
            prod_reg <= prod_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    assign prod = prod_reg;
    assign acc  = acc_reg;

endmodule

### src/biquad_lowpass_filter_unit.sv
// Second-order low-pass biquad, direct form II, with one shared multiplier.
// Channels: s_axis carries one signed sample per request; m_axis returns one
// filtered sample per request; cfg writes filter_enable, coef_b0, coef_a1,
// coef_a2 at indexes 0 to 3 (coefficients signed Q2.COEF_FRAC_BITS).
// Steps: with filtering enabled an accepted sample passes through two feedback
// products and their accumulation, one rounding step, one feedforward product
// and one output step before it shows on m_axis. The single multiply-accumulate
// unit does three products per sample, and a new sample is accepted only once
// the previous filtered one has been written to the output register. In bypass
// the sample shows on m_axis the cycle after it is accepted.
// Throughput: one sample per cycle in bypass while the receiver is ready.
// Reset clears the delay line, the coefficients and filter_enable, so the
// block starts in bypass. When the receiver stalls, the result waits in the
// output register; one more filtered sample may be accepted meanwhile, and it
// waits in its final step until the output register is free. A bypassed
// sample is held off until the output register is free.
// Depends on bqlp_pkg and bqlp_mac.
module biquad_lowpass_filter_unit #(
    parameter int SAMPLE_WIDTH   = bqlp_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = bqlp_pkg::COEF_FRAC_BITS_DEF,
    parameter int DELAY_WIDTH    = bqlp_pkg::DELAY_WIDTH_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // sample stream in
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]       s_axis_tdata,  // sample
    // filtered stream out
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]       m_axis_tdata,  // filtered
    // configuration writes
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [bqlp_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [COEF_FRAC_BITS+1:0]               cfg_data
);
    import bqlp_pkg::*;

    localparam int S       = SAMPLE_WIDTH;
    localparam int F       = COEF_FRAC_BITS;
    localparam int D       = DELAY_WIDTH;
    localparam int C_W     = F + 2;
    localparam int TDATA_W = ((S + 7) / 8) * 8;
    localparam int DREG_W  = (S > D) ? S : D;
    localparam int A_W     = DREG_W + 2;
    localparam int P_W     = A_W + C_W;
    localparam int ACC_W   = ((S + F + 1 > P_W) ? S + F + 1 : P_W) + 2;
    localparam int W0F_W   = ACC_W - F;
    localparam int YF_W    = P_W - F;

    localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1) <<< (F - 1);
    localparam logic signed [P_W-1:0]   PROD_HALF = P_W'(1) <<< (F - 1);
    localparam logic signed [S-1:0]     SMAX = {1'b0, {(S-1){1'b1}}};
    localparam logic signed [S-1:0]     SMIN = {1'b1, {(S-1){1'b0}}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_P1,
        ST_P2,
        ST_P3,
        ST_W0,
        ST_P4,
        ST_Y
    } state_t;

    // Configuration registers.
    logic                  enable_reg;
    logic signed [C_W-1:0] b0_reg;
    logic signed [C_W-1:0] a1_reg;
    logic signed [C_W-1:0] a2_reg;

    // Sequencer, delay line and output registers.
    state_t                   state_reg, state_next;
    logic signed [S-1:0]      sample_reg, sample_next;
    logic signed [DREG_W-1:0] delay_one_reg, delay_one_next;
    logic signed [DREG_W-1:0] delay_two_reg, delay_two_next;
    logic signed [DREG_W-1:0] w0_reg, w0_next;
    logic signed [A_W-1:0]    sum_reg, sum_next;
    logic                     out_valid_reg, out_valid_next;
    logic signed [S-1:0]      out_reg, out_next;

    // Shared unit interface.
    mac_ctl_t                 mac_ctl;
    logic signed [A_W-1:0]    mul_a;
    logic signed [C_W-1:0]    mul_b;
    logic signed [ACC_W-1:0]  load_val;
    logic signed [P_W-1:0]    prod;
    logic signed [ACC_W-1:0]  acc;

    // Datapath helpers.
    logic                     s_fire;
    logic                     m_fire;
    logic                     out_free;
    logic signed [S-1:0]      in_sample;
    logic signed [ACC_W-1:0]  acc_rnd;
    logic signed [W0F_W-1:0]  w0_full;
    logic                     w0_ovf;
    logic signed [DREG_W-1:0] w0_fixed;
    logic signed [P_W-1:0]    y_rnd;
    logic signed [YF_W-1:0]   y_full;
    logic signed [S-1:0]      y_sat;

    // A filtered request may start while a result waits; a bypassed one needs the output.
    assign in_sample = s_axis_tdata[S-1:0];
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && (out_free || enable_reg);
    assign s_fire    = s_axis_tvalid && s_axis_tready;
    assign m_fire    = out_valid_reg && m_axis_tready;
    assign cfg_ready = 1'b1;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = TDATA_W'($unsigned(out_reg));

    // Configuration writes; every index of the port maps to a register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            b0_reg     <= '0;
            a1_reg     <= '0;
            a2_reg     <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_FILTER_ENABLE: enable_reg <= cfg_data[0];
                REG_COEF_B0:       b0_reg     <= cfg_data;
                REG_COEF_A1:       a1_reg     <= cfg_data;
                REG_COEF_A2:       a2_reg     <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Round the feedback sum to sample scale and guard the delay range.
    assign acc_rnd  = acc + ACC_HALF;
    assign w0_full  = acc_rnd[ACC_W-1:F];
    assign w0_ovf   = !((&w0_full[W0F_W-1:D-1]) || !(|w0_full[W0F_W-1:D-1]));
    assign w0_fixed = w0_ovf ? DREG_W'(sample_reg) : w0_full[DREG_W-1:0];

    // Round the feedforward product and saturate to the sample range.
    assign y_rnd  = prod + PROD_HALF;
    assign y_full = y_rnd[P_W-1:F];
    always_comb
    begin
        if ((&y_full[YF_W-1:S-1]) || !(|y_full[YF_W-1:S-1]))
        begin
            y_sat = y_full[S-1:0];
        end
        else if (y_full[YF_W-1])
        begin
            y_sat = SMIN;
        end
        else
        begin
            y_sat = SMAX;
        end
    end

    // Operand selection for the shared unit.
    assign load_val = {{(ACC_W-S-F){sample_reg[S-1]}}, sample_reg, {F{1'b0}}};

    always_comb
    begin
        mac_ctl.mul_en = 1'b0;
        mac_ctl.acc_op = ACC_HOLD;
        mul_a          = A_W'(delay_one_reg);
        mul_b          = a1_reg;
        case (state_reg)
            ST_P1:
            begin
                mac_ctl.mul_en = 1'b1;
                mac_ctl.acc_op = ACC_LOAD;
            end
            ST_P2:
            begin
                mac_ctl.mul_en = 1'b1;
                mac_ctl.acc_op = ACC_SUB;
                mul_a          = A_W'(delay_two_reg);
                mul_b          = a2_reg;
            end
            ST_P3:
            begin
                mac_ctl.acc_op = ACC_SUB;
            end
            ST_P4:
            begin
                mac_ctl.mul_en = 1'b1;
                mul_a          = sum_reg;
                mul_b          = b0_reg;
            end
            default:
            begin
                mac_ctl.acc_op = ACC_HOLD;
            end
        endcase
    end

    bqlp_mac #(
        .A_W   (A_W),
        .B_W   (C_W),
        .ACC_W (ACC_W)
    ) u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (mac_ctl),
        .mul_a    (mul_a),
        .mul_b    (mul_b),
        .load_val (load_val),
        .prod     (prod),
        .acc      (acc)
    );

    // Sequencer next-state logic.
    always_comb
    begin
        state_next     = state_reg;
        sample_next    = sample_reg;
        delay_one_next = delay_one_reg;
        delay_two_next = delay_two_reg;
        w0_next        = w0_reg;
        sum_next       = sum_reg;
        out_next       = out_reg;
        out_valid_next = m_fire ? 1'b0 : out_valid_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    if (enable_reg)
                    begin
                        sample_next = in_sample;
                        state_next  = ST_P1;
                    end
                    else
                    begin
                        out_next       = in_sample;
                        out_valid_next = 1'b1;
                    end
                end
            end
            ST_P1: state_next = ST_P2;
            ST_P2: state_next = ST_P3;
            ST_P3: state_next = ST_W0;
            ST_W0:
            begin
                w0_next    = w0_fixed;
                sum_next   = A_W'(w0_fixed) + (A_W'(delay_one_reg) <<< 1)
                             + A_W'(delay_two_reg);
                state_next = ST_P4;
            end
            ST_P4: state_next = ST_Y;
            ST_Y:
            begin
                if (out_free)
                begin
                    out_next       = y_sat;
                    out_valid_next = 1'b1;
                    delay_two_next = delay_one_reg;
                    delay_one_next = w0_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            delay_one_reg <= '0;
            delay_two_reg <= '0;
            sample_reg    <= '0;
            w0_reg        <= '0;
            sum_reg       <= '0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            delay_one_reg <= delay_one_next;
            delay_two_reg <= delay_two_next;
            sample_reg    <= sample_next;
            w0_reg        <= w0_next;
            sum_reg       <= sum_next;
            out_reg       <= out_next;
        end
    end

`ifndef SYNTHESIS
    // A bypassed request comes straight out on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_fire && !enable_reg |=> out_valid_reg && out_reg == $past(in_sample))
        else $error("bypass request did not reach the output register");

    // The delay line moves only when a filtered result is written out.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(state_reg == ST_Y && out_free) |=> $stable(delay_one_reg)
                                             && $stable(delay_two_reg))
        else $error("delay line changed outside the output step");

    // On a filtered result the old first delay shifts into the second.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_Y && out_free |=> delay_two_reg == $past(delay_one_reg)
                                         && out_valid_reg)
        else $error("delay line did not shift with the filtered result");

    // The rounded and range-guarded feedback value is captured for the product step.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_W0 |=> w0_reg == $past(w0_fixed) && state_reg == ST_P4)
        else $error("rounded feedback value was not captured");
`endif

endmodule
